[sv/gps_fix_acquisition_sequencer_top_macros.svh]
// Assertion macros used by the GNSS fix acquisition sequencer core module
`ifndef GPS_FIX_ACQUISITION_SEQUENCER_TOP_MACROS_SVH
`define GPS_FIX_ACQUISITION_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GFAS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gfas assertion failed");

// Next-cycle implication, checked out of reset
`define GFAS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gfas assertion failed");

`endif

[sv/gfas_pkg.sv]
// Types and constants of the GNSS fix acquisition sequencer
package gfas_pkg;

	// Command codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_EXEC  = 2'd2;

	// Sequencer phases; code seven behaves like done
	typedef logic [2:0] phase_t;
	localparam phase_t PH_IDLE       = 3'd0;
	localparam phase_t PH_POWER_UP   = 3'd1;
	localparam phase_t PH_POWER_WAIT = 3'd2;
	localparam phase_t PH_MSG_START  = 3'd3;
	localparam phase_t PH_MSG_WAIT   = 3'd4;
	localparam phase_t PH_RETRY      = 3'd5;
	localparam phase_t PH_DONE       = 3'd6;

	// Finish causes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_FIX     = 2'd1;
	localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
	localparam logic [1:0] CAUSE_RETRIES = 2'd3;

	// Configuration register indexes and reset values
	localparam logic CFG_FIX_TIMEOUT = 1'b0;
	localparam logic CFG_MAX_RETRIES = 1'b1;
	localparam logic [15:0] FIX_TIMEOUT_RESET = 16'd900;
	localparam logic [2:0]  MAX_RETRIES_RESET = 3'd4;

	// One command item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_seconds;
		logic        receiver_powered;
		logic        power_error;
		logic        sentence_ready;
		logic        fix_good;
		logic        message_error;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic       busy_res;
		logic       do_power_restart;
		logic       do_power_down;
		logic       do_message_start;
		logic       do_message_stop;
		logic       select_modem_uart;
		logic       schedule_report;
		logic [1:0] finish_cause;
	} res_t;

endpackage

[sv/gfas_in_stage.sv]
// Input register stage: captures one command per transfer
module gfas_in_stage import gfas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	input  logic pop,
	output logic stage_valid,
	output cmd_t stage_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;

	// Free when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= in_cmd;
		end
	end

	assign stage_valid = valid_s1;
	assign stage_cmd   = cmd_s1;

endmodule

[sv/gfas_seq_core.sv]
// Sequencer state, configuration registers and single-step next-state logic
module gfas_seq_core import gfas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        advance,
	input  cmd_t        cmd,
	output res_t        res
);

`include "gps_fix_acquisition_sequencer_top_macros.svh"

	logic [15:0] fix_timeout_q;
	logic [2:0]  max_retries_q;

	logic        running_q, running_d;
	phase_t      phase_q, phase_d;
	logic [2:0]  retry_q, retry_d;
	logic [31:0] start_time_q, start_time_d;
	logic [1:0]  pending_q, pending_d;

	logic [31:0] elapsed;
	logic [2:0]  retry_inc;

	assign elapsed   = cmd.now_seconds - start_time_q;
	assign retry_inc = retry_q + 3'd1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_timeout_q <= FIX_TIMEOUT_RESET;
			max_retries_q <= MAX_RETRIES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_FIX_TIMEOUT: fix_timeout_q <= cfg_wdata;
				CFG_MAX_RETRIES: max_retries_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// One command step
	always_comb begin
		running_d    = running_q;
		phase_d      = phase_q;
		retry_d      = retry_q;
		start_time_d = start_time_q;
		pending_d    = pending_q;
		res          = '0;

		case (cmd.opcode)
			OP_START: begin
				if (!running_q) begin
					// start runs the power-up step at once
					running_d        = 1'b1;
					retry_d          = 3'd0;
					pending_d        = CAUSE_NONE;
					res.do_power_restart = 1'b1;
					phase_d          = PH_POWER_WAIT;
					start_time_d     = cmd.now_seconds;
				end
			end
			OP_STOP: begin
				// phase is kept, no report
				res.do_power_down     = 1'b1;
				res.do_message_stop   = 1'b1;
				res.select_modem_uart = 1'b1;
				running_d             = 1'b0;
			end
			OP_EXEC: begin
				if (running_q) begin
					case (phase_q)
						PH_IDLE: ;
						PH_POWER_UP: begin
							res.do_power_restart = 1'b1;
							phase_d              = PH_POWER_WAIT;
							start_time_d         = cmd.now_seconds;
						end
						PH_POWER_WAIT: begin
							if (cmd.receiver_powered) begin
								phase_d = PH_MSG_START;
							end else if (cmd.power_error) begin
								phase_d = PH_RETRY;
							end
						end
						PH_MSG_START: begin
							res.do_message_start = 1'b1;
							phase_d              = PH_MSG_WAIT;
						end
						PH_MSG_WAIT: begin
							if (cmd.sentence_ready) begin
								if (cmd.fix_good) begin
									pending_d = CAUSE_FIX;
									phase_d   = PH_DONE;
								end else if (elapsed > {16'd0, fix_timeout_q}) begin
									pending_d = CAUSE_TIMEOUT;
									phase_d   = PH_DONE;
								end else begin
									phase_d = PH_MSG_START;
								end
							end else if (cmd.message_error) begin
								phase_d = PH_RETRY;
							end
						end
						PH_RETRY: begin
							res.do_power_down = 1'b1;
							retry_d           = retry_inc;
							if (retry_inc < max_retries_q) begin
								phase_d = PH_POWER_UP;
							end else begin
								pending_d = CAUSE_RETRIES;
								phase_d   = PH_DONE;
							end
						end
						default: begin
							// done: shut down and report the cause
							res.do_power_down     = 1'b1;
							res.do_message_stop   = 1'b1;
							res.select_modem_uart = 1'b1;
							res.schedule_report   = 1'b1;
							res.finish_cause      = pending_q;
							running_d             = 1'b0;
							phase_d               = PH_IDLE;
							pending_d             = CAUSE_NONE;
						end
					endcase
				end
			end
			default: ;
		endcase

		res.busy_res = running_d;
	end

	// State update when an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			phase_q      <= PH_IDLE;
			retry_q      <= 3'd0;
			start_time_q <= 32'd0;
			pending_q    <= CAUSE_NONE;
		end else if (advance) begin
			running_q    <= running_d;
			phase_q      <= phase_d;
			retry_q      <= retry_d;
			start_time_q <= start_time_d;
			pending_q    <= pending_d;
		end
	end

	`GFAS_ASSERT_IMPL(a_cause_only_with_report, res.finish_cause != CAUSE_NONE, res.schedule_report)
	`GFAS_ASSERT_NEXT(a_report_clears_running, advance && res.schedule_report, !running_q && pending_q == CAUSE_NONE)
	`GFAS_ASSERT_NEXT(a_restart_enters_wait, advance && res.do_power_restart, phase_q == PH_POWER_WAIT && running_q)
	`GFAS_ASSERT_NEXT(a_start_clears_retries, advance && cmd.opcode == OP_START && !running_q, retry_q == 3'd0)

endmodule

[sv/gps_fix_acquisition_sequencer_top.sv]
// GNSS fix acquisition sequencer: top level with input stage, core and result register
//
// Usage:
//   Commands (start, stop, exec tick) arrive on the in_valid/in_ready channel together
//   with the seconds count and the power and message unit status flags.
//   Each accepted command yields exactly one result on out_valid/out_ready: the busy
//   flag, the command flags and, on completion, the finish cause.
//   A command taken on the input channel sits in the input register until the result
//   register can load; its result is then loaded there and raises out_valid.
//   Throughput: one command per cycle while the receiver keeps out_ready high; the state
//   update is a single pass of logic between the input and the result register.
//   When the receiver stalls (out_ready low) the result register holds its item, the
//   input register takes one more command, then in_ready drops until a transfer out.
//   Reset (arst_n low, asynchronous) clears the sequencer to idle, not running, zero
//   retries and restores fix_timeout_seconds = 900 and max_power_retries = 4.
//   Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at the clock
//   edge; the user makes them only while no command is in flight; the block does not enforce this.
module gps_fix_acquisition_sequencer_top import gfas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] now_seconds,
	input  logic        receiver_powered,
	input  logic        power_error,
	input  logic        sentence_ready,
	input  logic        fix_good,
	input  logic        message_error,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        busy_res,
	output logic        do_power_restart,
	output logic        do_power_down,
	output logic        do_message_start,
	output logic        do_message_stop,
	output logic        select_modem_uart,
	output logic        schedule_report,
	output logic [1:0]  finish_cause
);

	cmd_t in_cmd;
	cmd_t stage_cmd;
	logic stage_valid;
	logic out_load;
	logic pop;
	res_t step_res;
	res_t res_q;
	logic out_valid_q;

	assign in_cmd = '{
		opcode:           opcode,
		now_seconds:      now_seconds,
		receiver_powered: receiver_powered,
		power_error:      power_error,
		sentence_ready:   sentence_ready,
		fix_good:         fix_good,
		message_error:    message_error
	};

	// Result register can load when empty or being drained
	assign out_load = !out_valid_q || out_ready;
	assign pop      = stage_valid && out_load;

	gfas_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_cmd     (in_cmd),
		.pop        (pop),
		.stage_valid(stage_valid),
		.stage_cmd  (stage_cmd)
	);

	gfas_seq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.advance  (pop),
		.cmd      (stage_cmd),
		.res      (step_res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= stage_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= step_res;
		end
	end

	assign out_valid         = out_valid_q;
	assign busy_res          = res_q.busy_res;
	assign do_power_restart  = res_q.do_power_restart;
	assign do_power_down     = res_q.do_power_down;
	assign do_message_start  = res_q.do_message_start;
	assign do_message_stop   = res_q.do_message_stop;
	assign select_modem_uart = res_q.select_modem_uart;
	assign schedule_report   = res_q.schedule_report;
	assign finish_cause      = res_q.finish_cause;

endmodule
